@@ hdl/jel_pkg.sv @@
// Shared types and constants for the joystick event latch.
// No dependencies; used by jel_axis_div and joystick_event_latch.
package jel_pkg;

  // Item opcodes
  localparam logic [1:0] OpEvent  = 2'd0;
  localparam logic [1:0] OpSample = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;

  // Event type bytes
  localparam logic [7:0] TypeButton = 8'd1;
  localparam logic [7:0] TypeAxis   = 8'd2;

  // Configuration register indexes
  localparam logic [2:0] RegButtonCount = 3'd0;
  localparam logic [2:0] RegAxisCount   = 3'd1;
  localparam logic [2:0] RegScaleZero   = 3'd2;
  localparam logic [2:0] RegScaleOne    = 3'd3;
  localparam logic [2:0] RegScaleTwo    = 3'd4;
  localparam logic [2:0] RegScaleThree  = 3'd5;

  // Field widths and constants
  localparam int unsigned AxisW     = 16;
  localparam int unsigned ProdW     = 32;
  localparam int unsigned OutBtnW   = 32;
  localparam int unsigned NumScales = 4;
  localparam logic signed [AxisW-1:0] ScaleReset = 16'sd256;
  localparam logic [16:0] FullScale  = 17'd32767;
  localparam logic [16:0] FullScale2 = 17'd65534;

  typedef logic signed [AxisW-1:0] axis_t;
  typedef logic signed [ProdW-1:0] prod_t;

endpackage

@@ hdl/jel_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jel_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [2**AddrW];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/jel_axis_div.sv @@
// Divides a signed scale*value product by full scale (32767), truncating
// toward zero, and saturates to 16 bits. Depends on jel_pkg.
module jel_axis_div (
  input  jel_pkg::prod_t prod_i,
  output jel_pkg::axis_t quot_o
);

  logic        neg;
  logic [30:0] mag;
  logic [15:0] hi;
  logic [16:0] sum;
  logic [16:0] q;
  logic [16:0] q_neg;

  // a = hi*32768 + lo = hi*32767 + (hi + lo); hi + lo < 3*32767
  always_comb begin
    neg   = prod_i[jel_pkg::ProdW-1];
    mag   = neg ? 31'(-prod_i) : prod_i[30:0];
    hi    = mag[30:15];
    sum   = 17'(hi) + 17'(mag[14:0]);
    q     = 17'(hi) + 17'(sum >= jel_pkg::FullScale) + 17'(sum >= jel_pkg::FullScale2);
    q_neg = -q;
    if (neg) begin
      quot_o = q_neg[15:0];
    end else if (q > 17'd32767) begin
      quot_o = 16'sh7FFF;
    end else begin
      quot_o = q[15:0];
    end
  end

endmodule

@@ hdl/joystick_event_latch.sv @@
// Top level of the joystick event latch: button bitmaps, axis store in RAM,
// scale pipeline and output register. Depends on jel_pkg, jel_ram, jel_axis_div.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | opcode, event_type, index, value
//  out     | source    | out_valid_o / out_stall_i | buttons, clears, reading, ignored
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle unless the output stalls; each result is valid at the
// output register behind stage 1. Stage 1 holds the registered product and
// the axis RAM's registered read; a forwarding register covers an axis write
// and a read of the same axis on one edge. Reset clears buttons and counts,
// restores the scales and clears the per-axis valid bits, so unwritten axes
// read as zero. A stalled output holds the result, then stage 1, then the input.
module joystick_event_latch #(
  parameter int unsigned MAX_BUTTONS = 32,
  parameter int unsigned MAX_AXES    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  event_type_i,
  input  logic [7:0]  channel_index_i,
  input  logic signed [15:0] event_value_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] button_states_o,
  output logic [31:0] clears_pending_o,
  output logic signed [15:0] axis_reading_o,
  output logic        index_ignored_o
);

  localparam int unsigned AxAddrW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

  // Configuration registers
  logic [5:0]      btn_count_q;
  logic [2:0]      axis_count_q;
  jel_pkg::axis_t  scale_q [jel_pkg::NumScales];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_count_q  <= '0;
      axis_count_q <= '0;
      for (int i = 0; i < jel_pkg::NumScales; i++) begin
        scale_q[i] <= jel_pkg::ScaleReset;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        jel_pkg::RegButtonCount: btn_count_q  <= cfg_data_i[5:0];
        jel_pkg::RegAxisCount:   axis_count_q <= cfg_data_i[2:0];
        jel_pkg::RegScaleZero:   scale_q[0]   <= cfg_data_i;
        jel_pkg::RegScaleOne:    scale_q[1]   <= cfg_data_i;
        jel_pkg::RegScaleTwo:    scale_q[2]   <= cfg_data_i;
        jel_pkg::RegScaleThree:  scale_q[3]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic s1_valid_q, out_valid_q;
  logic s1_adv, in_acc;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Decode the incoming item
  logic [7:0] btn_lim, axis_lim;
  logic       is_event, btn_ev, axis_ev, btn_in, axis_in;
  logic       do_btn, do_axis_wr, do_read, do_sample, ignored;

  always_comb begin
    btn_lim   = (8'(btn_count_q) > 8'(MAX_BUTTONS)) ? 8'(MAX_BUTTONS) : 8'(btn_count_q);
    axis_lim  = (8'(axis_count_q) > 8'(MAX_AXES)) ? 8'(MAX_AXES) : 8'(axis_count_q);
    is_event  = (opcode_i == jel_pkg::OpEvent);
    btn_ev    = is_event && (event_type_i == jel_pkg::TypeButton);
    axis_ev   = is_event && (event_type_i == jel_pkg::TypeAxis);
    btn_in    = channel_index_i < btn_lim;
    axis_in   = channel_index_i < axis_lim;
    do_btn    = btn_ev && btn_in;
    do_axis_wr = axis_ev && axis_in;
    do_read   = (opcode_i == jel_pkg::OpRead) && axis_in;
    do_sample = (opcode_i == jel_pkg::OpSample);
    ignored   = (is_event && !do_btn && !do_axis_wr)
             || ((opcode_i == jel_pkg::OpRead) && !axis_in);
  end

  // Button bitmaps, updated as the item is taken
  logic [MAX_BUTTONS-1:0] btn_q, btn_d, clr_q, clr_d, sel_mask;

  for (genvar b = 0; b < MAX_BUTTONS; b++) begin : g_mask
    assign sel_mask[b] = (channel_index_i == 8'(b));
  end

  always_comb begin
    btn_d = btn_q;
    clr_d = clr_q;
    if (do_btn) begin
      if (event_value_i != '0) begin
        btn_d = btn_q | sel_mask;
        clr_d = clr_q & ~sel_mask;
      end else begin
        clr_d = clr_q | sel_mask;
      end
    end else if (do_sample) begin
      btn_d = btn_q & ~clr_q;
      clr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q <= '0;
      clr_q <= '0;
    end else if (in_acc) begin
      btn_q <= btn_d;
      clr_q <= clr_d;
    end
  end

  // Stage 1: registered product and item snapshot
  jel_pkg::prod_t         s1_prod_q;
  logic                   s1_wr_q, s1_rd_q, s1_ign_q;
  logic [AxAddrW-1:0]     s1_addr_q;
  logic [MAX_BUTTONS-1:0] s1_btn_q, s1_clr_q;

  // Fill an empty stage 1 even while the output is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv || !s1_valid_q) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_prod_q <= scale_q[channel_index_i[1:0]] * event_value_i;
      s1_wr_q   <= do_axis_wr;
      s1_rd_q   <= do_read;
      s1_ign_q  <= ignored;
      s1_addr_q <= channel_index_i[AxAddrW-1:0];
      s1_btn_q  <= btn_d;
      s1_clr_q  <= clr_d;
    end
  end

  // Scale and write back to the axis store
  jel_pkg::axis_t quot;
  logic           wr_en;

  jel_axis_div u_div (
    .prod_i (s1_prod_q),
    .quot_o (quot)
  );

  assign wr_en = s1_valid_q && s1_adv && s1_wr_q;

  jel_pkg::axis_t ram_rdata;

  jel_ram #(
    .Width (jel_pkg::AxisW),
    .Depth (MAX_AXES),
    .AddrW (AxAddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (quot),
    .re_i    (in_acc),
    .raddr_i (channel_index_i[AxAddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Written flags for axes; an unwritten axis reads as zero
  logic [2**AxAddrW-1:0] ax_vld_q;
  logic                  rd_vld_q, fwd_hit_q;
  jel_pkg::axis_t        fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_vld_q <= '0;
    end else if (wr_en) begin
      ax_vld_q[s1_addr_q] <= 1'b1;
    end
  end

  // Forward a write that lands on the same edge as the read
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_vld_q   <= ax_vld_q[channel_index_i[AxAddrW-1:0]];
      fwd_hit_q  <= wr_en && (s1_addr_q == channel_index_i[AxAddrW-1:0]);
      fwd_data_q <= quot;
    end
  end

  jel_pkg::axis_t reading;

  always_comb begin
    if (!s1_rd_q) begin
      reading = '0;
    end else if (fwd_hit_q) begin
      reading = fwd_data_q;
    end else if (rd_vld_q) begin
      reading = ram_rdata;
    end else begin
      reading = '0;
    end
  end

  // Output register
  logic [MAX_BUTTONS-1:0] out_btn_q, out_clr_q;
  jel_pkg::axis_t         out_read_q;
  logic                   out_ign_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_btn_q  <= s1_btn_q;
      out_clr_q  <= s1_clr_q;
      out_read_q <= reading;
      out_ign_q  <= s1_ign_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign axis_reading_o  = out_read_q;
  assign index_ignored_o = out_ign_q;

  // Show the low 32 button bits; fewer buttons are zero-extended
  if (MAX_BUTTONS >= jel_pkg::OutBtnW) begin : g_out_wide
    assign button_states_o  = out_btn_q[jel_pkg::OutBtnW-1:0];
    assign clears_pending_o = out_clr_q[jel_pkg::OutBtnW-1:0];
  end else begin : g_out_narrow
    assign button_states_o  = {{(jel_pkg::OutBtnW-MAX_BUTTONS){1'b0}}, out_btn_q};
    assign clears_pending_o = {{(jel_pkg::OutBtnW-MAX_BUTTONS){1'b0}}, out_clr_q};
  end

endmodule
